// ===== src/hdbb_pkg.sv =====
// hdbb_pkg: shared types, codes and constants of the half-duplex burst bridge
// no dependencies; used by every module of the bridge
package hdbb_pkg;

   localparam int RING_DEPTH_DEF    = 512;
   localparam int CAPTURE_DEPTH_DEF = 16;
   localparam int QUEUE_DEPTH_DEF   = 4;

   localparam int N_COUNTERS = 21;
   localparam int MAX_WORDS  = 32;
   localparam logic [15:0] LEN_MAX = 16'hffff;

   // statistic counter slots, also the statistic word order
   localparam int C_LBURSTS = 0;
   localparam int C_LBYTES  = 1;
   localparam int C_KBURSTS = 2;
   localparam int C_KBYTES  = 3;
   localparam int C_PMIN    = 4;
   localparam int C_PMAX    = 5;
   localparam int C_PSUM    = 6;
   localparam int C_PN      = 7;
   localparam int C_BMAX    = 8;
   localparam int C_TMIN    = 9;
   localparam int C_TMAX    = 10;
   localparam int C_TN      = 11;
   localparam int C_MISS    = 12;
   localparam int C_MCONSEC = 13;
   localparam int C_LINKUP  = 14;
   localparam int C_DROPS   = 15;
   localparam int C_ELOVR   = 16;
   localparam int C_ELOCOVR = 17;
   localparam int C_ECONT   = 18;
   localparam int C_EFRAME  = 19;
   localparam int C_ELINK   = 20;

   localparam int STAT_CAP_COUNT = 21;
   localparam int STAT_CAP_LEN   = 22;
   localparam int STAT_CAP_BYTES = 23;

   // configuration register indexes
   localparam logic CSR_GUARD   = 1'b0;
   localparam logic CSR_TIMEOUT = 1'b1;
   localparam logic [15:0] GUARD_RESET   = 16'd1000;
   localparam logic [23:0] TIMEOUT_RESET = 24'd500000;

   typedef enum logic [2:0] {
      CMD_TICK      = 3'd0,
      CMD_LOCAL     = 3'd1,
      CMD_LINK      = 3'd2,
      CMD_SNAP      = 3'd3,
      CMD_FRAME_ERR = 3'd4,
      CMD_LOCAL_OVR = 3'd5,
      CMD_LINK_ERR  = 3'd6
   } cmd_type;

   typedef enum logic [2:0] {
      KIND_TO_LINK  = 3'd0,
      KIND_TO_LOCAL = 3'd1,
      KIND_TAKE     = 3'd2,
      KIND_RELEASE  = 3'd3,
      KIND_STAT     = 3'd4
   } kind_type;

   typedef struct packed {
      cmd_type    cmd;
      logic [7:0] data_byte;
      logic       link_tx_ready;
      logic       local_tx_ready;
      logic       local_tx_idle;
      logic [7:0] link_error_count;
      logic [7:0] link_overrun_count;
   } item_type;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  byte_out;
      logic [4:0]  stat_index;
      logic [31:0] stat_value;
      logic        last;
   } result_type;

endpackage

// ===== src/hdbb_if.sv =====
// hdbb channel interfaces: request, response and register write channels
// depends on nothing; payload widths follow the bridge item formats
interface hdbb_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] command;
   logic [7:0] data_byte;
   logic       link_tx_ready;
   logic       local_tx_ready;
   logic       local_tx_idle;
   logic [7:0] link_error_count;
   logic [7:0] link_overrun_count;

   modport source (output valid, command, data_byte, link_tx_ready, local_tx_ready,
                   local_tx_idle, link_error_count, link_overrun_count, input ready);
   modport sink (input valid, command, data_byte, link_tx_ready, local_tx_ready,
                 local_tx_idle, link_error_count, link_overrun_count, output ready);
endinterface

interface hdbb_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  result_kind;
   logic [7:0]  byte_out;
   logic [4:0]  stat_index;
   logic [31:0] stat_value;
   logic        last;

   modport source (output valid, result_kind, byte_out, stat_index, stat_value, last,
                   input ready);
   modport sink (input valid, result_kind, byte_out, stat_index, stat_value, last,
                 output ready);
endinterface

interface hdbb_csr_if;
   logic        valid;
   logic        ready;
   logic        index;
   logic [23:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ===== src/half_duplex_burst_bridge.sv =====
// half_duplex_burst_bridge: top level of the half-duplex burst bridge
// depends on hdbb_pkg, hdbb_if, hdbb_front, hdbb_queue and hdbb_back
//
// the bridge takes one item per clock while the queue has room: a classifying front end
// pushes items into a short queue, and the back end executes one item per cycle while
// results drain and no snapshot or held result stalls it, so ticks, local bytes, link
// bytes and error reports run back to back. results leave through an output register; a
// tick that sends a ring byte and also releases the wire gives two results, and the back
// end waits until the second one has moved to the output register. a snapshot streams its
// statistic words one per cycle while the output drains (23 plus one per four capture
// bytes, at most 32) and holds the back end until its last word is loaded while the queue
// keeps accepting. the reply ring is a memory with one write port and one registered read
// port that always points at the next byte to send. register writes are taken at once.
module half_duplex_burst_bridge #(
   parameter int RING_DEPTH    = hdbb_pkg::RING_DEPTH_DEF,
   parameter int CAPTURE_DEPTH = hdbb_pkg::CAPTURE_DEPTH_DEF,
   parameter int QUEUE_DEPTH   = hdbb_pkg::QUEUE_DEPTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   hdbb_req_if.sink   req_ch,
   hdbb_rsp_if.source rsp_ch,
   hdbb_csr_if.sink   csr_ch
);

   // front to queue
   logic               push_valid, push_ready;
   hdbb_pkg::item_type push_item;

   // queue to back
   logic               pop_valid, pop_ready;
   hdbb_pkg::item_type pop_item;

   // classify and drop the unused command code
   hdbb_front u_front (
      .req        (req_ch),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item)
   );

   // decouples request acceptance from result back-pressure
   hdbb_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item)
   );

   // timers, statistics, reply ring and result stream
   hdbb_back #(
      .RING_DEPTH    (RING_DEPTH),
      .CAPTURE_DEPTH (CAPTURE_DEPTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (pop_valid),
      .item_ready (pop_ready),
      .item       (pop_item),
      .csr        (csr_ch),
      .rsp        (rsp_ch)
   );

endmodule

// ===== src/hdbb_front.sv =====
// hdbb_front: accepts request items and classifies the command
// depends on hdbb_pkg and hdbb_req_if; feeds hdbb_queue
module hdbb_front (
   hdbb_req_if.sink            req,
   output logic                push_valid,
   input  logic                push_ready,
   output hdbb_pkg::item_type  push_item
);

   logic known;

   // the unused command code is taken and dropped here
   assign known      = (req.command <= 3'(hdbb_pkg::CMD_LINK_ERR));
   assign req.ready  = push_ready;
   assign push_valid = req.valid && known;

   always_comb begin
      push_item.cmd                = hdbb_pkg::cmd_type'(req.command);
      push_item.data_byte          = req.data_byte;
      push_item.link_tx_ready      = req.link_tx_ready;
      push_item.local_tx_ready     = req.local_tx_ready;
      push_item.local_tx_idle      = req.local_tx_idle;
      push_item.link_error_count   = req.link_error_count;
      push_item.link_overrun_count = req.link_overrun_count;
   end

endmodule

// ===== src/hdbb_queue.sv =====
// hdbb_queue: short item queue between front and back
// depends on hdbb_pkg for the item type
module hdbb_queue #(
   parameter int DEPTH = hdbb_pkg::QUEUE_DEPTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   output logic               push_ready,
   input  hdbb_pkg::item_type push_item,
   output logic               pop_valid,
   input  logic               pop_ready,
   output hdbb_pkg::item_type pop_item
);

   localparam int PW    = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PW-1:0]    PTR_LAST = PW'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   hdbb_pkg::item_type slot_ff [DEPTH];
   logic [PW-1:0]    wr_ff, wr_in, rd_ff, rd_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic push, pop;

   assign push_ready = (count_ff != CNT_FULL);
   assign pop_valid  = (count_ff != '0);
   assign pop_item   = slot_ff[rd_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_in    = push ? ((wr_ff == PTR_LAST) ? '0 : wr_ff + 1'b1) : wr_ff;
      rd_in    = pop ? ((rd_ff == PTR_LAST) ? '0 : rd_ff + 1'b1) : rd_ff;
      count_in = count_ff + CNT_W'(push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_item;
      end
   end

endmodule

// ===== src/hdbb_back.sv =====
// hdbb_back: executes items, holds timers, counters, reply ring and capture
// depends on hdbb_pkg, hdbb_rsp_if and hdbb_csr_if; fed by hdbb_queue
module hdbb_back #(
   parameter int RING_DEPTH    = hdbb_pkg::RING_DEPTH_DEF,
   parameter int CAPTURE_DEPTH = hdbb_pkg::CAPTURE_DEPTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               item_valid,
   output logic               item_ready,
   input  hdbb_pkg::item_type item,
   hdbb_csr_if.sink           csr,
   hdbb_rsp_if.source         rsp
);

   localparam int PTR_W     = $clog2(RING_DEPTH);
   localparam int CAP_IW    = $clog2(CAPTURE_DEPTH);
   localparam int LEN0_W    = $clog2(CAPTURE_DEPTH + 1);
   localparam int CAP_WORDS = (CAPTURE_DEPTH + 3) / 4;
   localparam int SNAP_TOT  = hdbb_pkg::STAT_CAP_BYTES + CAP_WORDS;
   localparam int SNAP_N    = (SNAP_TOT > hdbb_pkg::MAX_WORDS) ? hdbb_pkg::MAX_WORDS : SNAP_TOT;
   localparam logic [4:0]        SNAP_LAST = 5'(SNAP_N - 1);
   localparam logic [PTR_W-1:0]  RING_LAST = PTR_W'(RING_DEPTH - 1);
   localparam logic [LEN0_W-1:0] CAP_FULL  = LEN0_W'(CAPTURE_DEPTH);
   localparam int N = hdbb_pkg::N_COUNTERS;

   function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
      ring_next = (p == RING_LAST) ? '0 : p + 1'b1;
   endfunction

   // configuration
   logic [15:0] guard_ff;
   logic [23:0] timeout_ff;

   // timing and mode state
   logic [31:0] now_ff, now_in;
   logic local_burst_ff, local_burst_in, driving_ff, driving_in;
   logic awaiting_ff, awaiting_in, link_burst_ff, link_burst_in;
   logic prev_valid_ff, prev_valid_in;
   logic [31:0] local_last_ff, local_last_in, start_ff, start_in, end_ff, end_in;
   logic [31:0] prev_ff, prev_in, link_last_ff, link_last_in;

   // ring
   logic [7:0] ring_mem [RING_DEPTH];
   logic [7:0] ring_rd_ff;
   logic [PTR_W-1:0] head_ff, head_in, tail_ff, tail_in;
   logic ring_we;

   // statistics and capture
   logic [31:0] cnt_ff [N];
   logic [31:0] cnt_in [N];
   logic [7:0]  cap_ff [CAPTURE_DEPTH];
   logic [7:0]  cap_in [CAPTURE_DEPTH];
   logic [LEN0_W-1:0] len0_ff, len0_in, base0;
   logic [15:0] len1_ff, len1_in, base1;

   // output side
   hdbb_pkg::result_type out_ff, out_in, pend_ff, pend_in, r0, r1, snap_res;
   logic out_valid_ff, out_valid_in, pend_valid_ff, pend_valid_in;
   logic r0_valid, r1_valid;
   logic snap_busy_ff, snap_busy_in;
   logic [4:0] snap_idx_ff, snap_idx_in;

   logic slot_free, go, snap_load;
   logic [31:0] tick_now, since_local, since_link, period, turn, burst_len;
   logic [31:0] guard_ext, timeout_ext, snap_word;
   logic [4:0] cap_w;
   logic [7:0] bi;

   assign csr.ready  = 1'b1;
   assign slot_free  = !out_valid_ff || rsp.ready;
   assign item_ready = slot_free && !snap_busy_ff && !pend_valid_ff;
   assign go         = item_valid && item_ready;
   assign snap_load  = snap_busy_ff && slot_free;

   assign tick_now    = now_ff + 32'd1;
   assign since_local = tick_now - local_last_ff;
   assign since_link  = tick_now - link_last_ff;
   assign period      = now_ff - prev_ff;
   assign turn        = now_ff - end_ff;
   assign burst_len   = local_last_ff - start_ff;
   assign guard_ext   = {16'd0, guard_ff};
   assign timeout_ext = {8'd0, timeout_ff};
   assign base0       = local_burst_ff ? len0_ff : '0;
   assign base1       = local_burst_ff ? len1_ff : '0;

   assign rsp.valid       = out_valid_ff;
   assign rsp.result_kind = out_ff.kind;
   assign rsp.byte_out    = out_ff.byte_out;
   assign rsp.stat_index  = out_ff.stat_index;
   assign rsp.stat_value  = out_ff.stat_value;
   assign rsp.last        = out_ff.last;

   // statistic word selection
   always_comb begin
      snap_word = '0;
      cap_w     = snap_idx_ff - 5'(hdbb_pkg::STAT_CAP_BYTES);
      bi        = '0;
      if (snap_idx_ff < 5'(N)) begin
         for (int i = 0; i < N; i++) begin
            if (snap_idx_ff == 5'(i)) snap_word = cnt_ff[i];
         end
      end else if (snap_idx_ff == 5'(hdbb_pkg::STAT_CAP_COUNT)) begin
         snap_word = 32'(len0_ff);
      end else if (snap_idx_ff == 5'(hdbb_pkg::STAT_CAP_LEN)) begin
         snap_word = {16'd0, len1_ff};
      end else begin
         for (int j = 0; j < 4; j++) begin
            bi = {1'b0, cap_w, 2'b00} + 8'(j);
            if (bi < 8'(CAPTURE_DEPTH)) snap_word[8*j +: 8] = cap_ff[bi[CAP_IW-1:0]];
         end
      end
      snap_res.kind       = hdbb_pkg::KIND_STAT;
      snap_res.byte_out   = '0;
      snap_res.stat_index = snap_idx_ff;
      snap_res.stat_value = snap_word;
      snap_res.last       = (snap_idx_ff == SNAP_LAST);
   end

   // item execution
   always_comb begin
      now_in         = now_ff;
      local_burst_in = local_burst_ff;
      driving_in     = driving_ff;
      awaiting_in    = awaiting_ff;
      link_burst_in  = link_burst_ff;
      prev_valid_in  = prev_valid_ff;
      local_last_in  = local_last_ff;
      start_in       = start_ff;
      end_in         = end_ff;
      prev_in        = prev_ff;
      link_last_in   = link_last_ff;
      head_in        = head_ff;
      tail_in        = tail_ff;
      ring_we        = 1'b0;
      cnt_in         = cnt_ff;
      cap_in         = cap_ff;
      len0_in        = len0_ff;
      len1_in        = len1_ff;
      snap_busy_in   = snap_busy_ff;
      snap_idx_in    = snap_idx_ff;
      r0_valid       = 1'b0;
      r1_valid       = 1'b0;
      r0             = '0;
      r1             = '0;

      if (go) begin
         unique case (item.cmd)
            hdbb_pkg::CMD_TICK: begin
               now_in = tick_now;
               // guard time ends the local burst
               if (local_burst_ff && since_local >= guard_ext) begin
                  local_burst_in = 1'b0;
                  end_in         = local_last_ff;
                  awaiting_in    = 1'b1;
                  if (burst_len > cnt_ff[hdbb_pkg::C_BMAX]) cnt_in[hdbb_pkg::C_BMAX] = burst_len;
               end
               if (link_burst_ff && since_link >= guard_ext) link_burst_in = 1'b0;
               if (!driving_ff) begin
                  if (head_ff != tail_ff) begin
                     if (local_burst_in) begin
                        cnt_in[hdbb_pkg::C_ECONT] = cnt_ff[hdbb_pkg::C_ECONT] + 32'd1;
                     end else if (since_local >= guard_ext) begin
                        driving_in = 1'b1;
                        r0_valid   = 1'b1;
                        r0.kind    = hdbb_pkg::KIND_TAKE;
                     end
                  end
               end else begin
                  if (head_ff != tail_ff && item.local_tx_ready) begin
                     r0_valid    = 1'b1;
                     r0.kind     = hdbb_pkg::KIND_TO_LOCAL;
                     r0.byte_out = ring_rd_ff;
                     tail_in     = ring_next(tail_ff);
                  end
                  if (head_ff == tail_in && item.local_tx_idle) begin
                     driving_in    = 1'b0;
                     local_last_in = tick_now;
                     if (r0_valid) begin
                        r1_valid = 1'b1;
                        r1.kind  = hdbb_pkg::KIND_RELEASE;
                     end else begin
                        r0_valid = 1'b1;
                        r0.kind  = hdbb_pkg::KIND_RELEASE;
                     end
                  end
               end
               // link watchdog
               if (cnt_ff[hdbb_pkg::C_LINKUP] != '0 && since_link > timeout_ext) begin
                  cnt_in[hdbb_pkg::C_LINKUP] = '0;
                  cnt_in[hdbb_pkg::C_DROPS]  = cnt_ff[hdbb_pkg::C_DROPS] + 32'd1;
                  head_in = '0;
                  tail_in = '0;
               end
            end
            hdbb_pkg::CMD_LOCAL: begin
               if (!local_burst_ff) begin
                  local_burst_in = 1'b1;
                  start_in       = now_ff;
                  cnt_in[hdbb_pkg::C_LBURSTS] = cnt_ff[hdbb_pkg::C_LBURSTS] + 32'd1;
                  if (prev_valid_ff) begin
                     if (period < cnt_ff[hdbb_pkg::C_PMIN]) cnt_in[hdbb_pkg::C_PMIN] = period;
                     if (period > cnt_ff[hdbb_pkg::C_PMAX]) cnt_in[hdbb_pkg::C_PMAX] = period;
                     cnt_in[hdbb_pkg::C_PSUM] = cnt_ff[hdbb_pkg::C_PSUM] + period;
                     cnt_in[hdbb_pkg::C_PN]   = cnt_ff[hdbb_pkg::C_PN] + 32'd1;
                  end
                  prev_in       = now_ff;
                  prev_valid_in = 1'b1;
                  if (awaiting_ff && cnt_ff[hdbb_pkg::C_LINKUP] != '0) begin
                     cnt_in[hdbb_pkg::C_MISS]    = cnt_ff[hdbb_pkg::C_MISS] + 32'd1;
                     cnt_in[hdbb_pkg::C_MCONSEC] = cnt_ff[hdbb_pkg::C_MCONSEC] + 32'd1;
                  end
                  awaiting_in = 1'b0;
               end
               local_last_in = now_ff;
               cnt_in[hdbb_pkg::C_LBYTES] = cnt_ff[hdbb_pkg::C_LBYTES] + 32'd1;
               len0_in = base0;
               if (base0 < CAP_FULL) begin
                  cap_in[base0[CAP_IW-1:0]] = item.data_byte;
                  len0_in = base0 + 1'b1;
               end
               len1_in = (base1 < hdbb_pkg::LEN_MAX) ? base1 + 16'd1 : base1;
               if (item.link_tx_ready) begin
                  r0_valid    = 1'b1;
                  r0.kind     = hdbb_pkg::KIND_TO_LINK;
                  r0.byte_out = item.data_byte;
               end else begin
                  cnt_in[hdbb_pkg::C_ELOVR] = cnt_ff[hdbb_pkg::C_ELOVR] + 32'd1;
               end
            end
            hdbb_pkg::CMD_LINK: begin
               if (!link_burst_ff) begin
                  link_burst_in = 1'b1;
                  cnt_in[hdbb_pkg::C_KBURSTS] = cnt_ff[hdbb_pkg::C_KBURSTS] + 32'd1;
               end
               link_last_in = now_ff;
               cnt_in[hdbb_pkg::C_KBYTES] = cnt_ff[hdbb_pkg::C_KBYTES] + 32'd1;
               cnt_in[hdbb_pkg::C_LINKUP] = 32'd1;
               if (awaiting_ff) begin
                  if (turn < cnt_ff[hdbb_pkg::C_TMIN]) cnt_in[hdbb_pkg::C_TMIN] = turn;
                  if (turn > cnt_ff[hdbb_pkg::C_TMAX]) cnt_in[hdbb_pkg::C_TMAX] = turn;
                  cnt_in[hdbb_pkg::C_TN]      = cnt_ff[hdbb_pkg::C_TN] + 32'd1;
                  cnt_in[hdbb_pkg::C_MCONSEC] = '0;
                  awaiting_in = 1'b0;
               end
               if (ring_next(head_ff) == tail_ff) begin
                  cnt_in[hdbb_pkg::C_ELOCOVR] = cnt_ff[hdbb_pkg::C_ELOCOVR] + 32'd1;
               end else begin
                  ring_we = 1'b1;
                  head_in = ring_next(head_ff);
               end
            end
            hdbb_pkg::CMD_SNAP: begin
               snap_busy_in = 1'b1;
               snap_idx_in  = '0;
            end
            hdbb_pkg::CMD_FRAME_ERR: begin
               cnt_in[hdbb_pkg::C_EFRAME] = cnt_ff[hdbb_pkg::C_EFRAME] + 32'd1;
            end
            hdbb_pkg::CMD_LOCAL_OVR: begin
               cnt_in[hdbb_pkg::C_ELOCOVR] = cnt_ff[hdbb_pkg::C_ELOCOVR] + 32'd1;
            end
            hdbb_pkg::CMD_LINK_ERR: begin
               cnt_in[hdbb_pkg::C_ELINK] = cnt_ff[hdbb_pkg::C_ELINK] + 32'(item.link_error_count);
               cnt_in[hdbb_pkg::C_ELOVR] = cnt_ff[hdbb_pkg::C_ELOVR]
                                           + 32'(item.link_overrun_count);
            end
            default: begin
            end
         endcase
      end else if (snap_load) begin
         snap_idx_in = snap_idx_ff + 5'd1;
         if (snap_idx_ff == SNAP_LAST) begin
            // window reset keeps consecutive misses and link state
            snap_busy_in = 1'b0;
            for (int i = 0; i < N; i++) begin
               if (i != hdbb_pkg::C_MCONSEC && i != hdbb_pkg::C_LINKUP) cnt_in[i] = '0;
            end
            cnt_in[hdbb_pkg::C_PMIN] = '1;
            cnt_in[hdbb_pkg::C_TMIN] = '1;
         end
      end
      r0.last = !r1_valid;
      r1.last = 1'b1;
   end

   // output register and second-result holding slot
   always_comb begin
      out_in        = out_ff;
      out_valid_in  = out_valid_ff;
      pend_in       = pend_ff;
      pend_valid_in = pend_valid_ff;
      priority if (go && r0_valid) begin
         out_in        = r0;
         out_valid_in  = 1'b1;
         pend_in       = r1;
         pend_valid_in = r1_valid;
      end else if (snap_load) begin
         out_in       = snap_res;
         out_valid_in = 1'b1;
      end else if (out_valid_ff && rsp.ready) begin
         if (pend_valid_ff) begin
            out_in        = pend_ff;
            pend_valid_in = 1'b0;
         end else begin
            out_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         guard_ff       <= hdbb_pkg::GUARD_RESET;
         timeout_ff     <= hdbb_pkg::TIMEOUT_RESET;
         now_ff         <= '0;
         local_burst_ff <= 1'b0;
         driving_ff     <= 1'b0;
         awaiting_ff    <= 1'b0;
         link_burst_ff  <= 1'b0;
         prev_valid_ff  <= 1'b0;
         local_last_ff  <= '0;
         start_ff       <= '0;
         end_ff         <= '0;
         prev_ff        <= '0;
         link_last_ff   <= '0;
         head_ff        <= '0;
         tail_ff        <= '0;
         // minima start at all ones
         for (int i = 0; i < N; i++)
            cnt_ff[i] <= (i == hdbb_pkg::C_PMIN || i == hdbb_pkg::C_TMIN) ? 32'hffff_ffff
                                                                        : 32'd0;
         for (int i = 0; i < CAPTURE_DEPTH; i++) cap_ff[i] <= '0;
         len0_ff        <= '0;
         len1_ff        <= '0;
         out_valid_ff   <= 1'b0;
         pend_valid_ff  <= 1'b0;
         snap_busy_ff   <= 1'b0;
         snap_idx_ff    <= '0;
      end else begin
         if (csr.valid) begin
            if (csr.index == hdbb_pkg::CSR_GUARD) guard_ff <= csr.data[15:0];
            else timeout_ff <= csr.data;
         end
         now_ff         <= now_in;
         local_burst_ff <= local_burst_in;
         driving_ff     <= driving_in;
         awaiting_ff    <= awaiting_in;
         link_burst_ff  <= link_burst_in;
         prev_valid_ff  <= prev_valid_in;
         local_last_ff  <= local_last_in;
         start_ff       <= start_in;
         end_ff         <= end_in;
         prev_ff        <= prev_in;
         link_last_ff   <= link_last_in;
         head_ff        <= head_in;
         tail_ff        <= tail_in;
         cnt_ff         <= cnt_in;
         cap_ff         <= cap_in;
         len0_ff        <= len0_in;
         len1_ff        <= len1_in;
         out_valid_ff   <= out_valid_in;
         pend_valid_ff  <= pend_valid_in;
         snap_busy_ff   <= snap_busy_in;
         snap_idx_ff    <= snap_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      pend_ff <= pend_in;
   end

   // reply ring, read port follows the next tail with write bypass
   always_ff @(posedge clock) begin
      if (ring_we) ring_mem[head_ff] <= item.data_byte;
      if (ring_we && head_ff == tail_in) ring_rd_ff <= item.data_byte;
      else ring_rd_ff <= ring_mem[tail_in];
   end

   a_pend_has_out: assert property (@(posedge clock) disable iff (reset)
      pend_valid_ff |-> out_valid_ff)
      else $error("second result held without a first");

   a_pend_is_release: assert property (@(posedge clock) disable iff (reset)
      pend_valid_ff |-> pend_ff.kind == hdbb_pkg::KIND_RELEASE)
      else $error("held second result is not a wire release");

   a_snap_no_pend: assert property (@(posedge clock) disable iff (reset)
      snap_busy_ff |-> !pend_valid_ff)
      else $error("snapshot running with a held result");

   a_drop_empties_ring: assert property (@(posedge clock) disable iff (reset)
      go && item.cmd == hdbb_pkg::CMD_TICK && cnt_ff[hdbb_pkg::C_LINKUP] != '0
      && since_link > timeout_ext |=> head_ff == tail_ff)
      else $error("link drop left bytes in the ring");

endmodule
